// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the top level of the wave drive sequencer
// no dependencies; the check bodies are left out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define ASSERT_CHK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// same edge implication: when ante holds, cons must hold
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_CHK(label, clk, rst_n, prop, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/swds_pkg.sv -----
// types and constants of the stepper wave drive sequencer
// no dependencies; used by every module of the block
package swds_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_BASE_PERIOD      = cfg_idx_t'(0);
  localparam cfg_idx_t REG_PERIOD_DECREMENT = cfg_idx_t'(1);

  // register reset values before truncation to the period width
  localparam logic [31:0] BASE_PERIOD_RESET = 32'h000F_FFFF;
  localparam logic [31:0] PERIOD_DEC_RESET  = 32'h0002_0000;

  // phase counter width, holds two to the seventh
  localparam int PHASES_W = 8;

  // coil drive codes
  localparam logic [3:0] COIL_D = 4'h8;
  localparam logic [3:0] COIL_B = 4'h2;
  localparam logic [3:0] COIL_C = 4'h4;
  localparam logic [3:0] COIL_A = 4'h1;

  typedef struct packed {
    logic       enable_switch;
    logic       start_press;
    logic       direction;
    logic [2:0] step_code;
    logic [2:0] speed_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0] coil_pattern;
    logic       ready_led;
    logic       busy_res;
  } out_item_t;

  // forward order 8,2,4,1 and reverse order 1,4,2,8
  function automatic logic [3:0] pattern_at(input logic fwd, input logic [1:0] idx);
    logic [3:0] pat;
    pat = COIL_A;
    case (idx)
      2'd0:    pat = fwd ? COIL_D : COIL_A;
      2'd1:    pat = fwd ? COIL_B : COIL_C;
      2'd2:    pat = fwd ? COIL_C : COIL_B;
      2'd3:    pat = fwd ? COIL_A : COIL_D;
      default: pat = COIL_A;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/core/swds_cfg.sv -----
// configuration registers: base phase period and period decrement
// depends on swds_pkg
module swds_cfg #(
  parameter int PERIOD_WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  swds_pkg::cfg_idx_t      cfg_index,
  input  logic [PERIOD_WIDTH-1:0] cfg_wdata,
  output logic [PERIOD_WIDTH-1:0] base_period,
  output logic [PERIOD_WIDTH-1:0] period_decrement
);
  import swds_pkg::*;

  logic [PERIOD_WIDTH-1:0] base_period_r;
  logic [PERIOD_WIDTH-1:0] period_dec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_period_r <= PERIOD_WIDTH'(BASE_PERIOD_RESET);
      period_dec_r  <= PERIOD_WIDTH'(PERIOD_DEC_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_PERIOD:      base_period_r <= cfg_wdata;
        REG_PERIOD_DECREMENT: period_dec_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign base_period      = base_period_r;
  assign period_decrement = period_dec_r;

endmodule

// ----- rtl/core/swds_core.sv -----
// run state and per-tick next-state logic of the wave drive sequencer
// depends on swds_pkg
module swds_core #(
  parameter int PERIOD_WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  swds_pkg::in_item_t      item,
  input  logic [PERIOD_WIDTH-1:0] base_period,
  input  logic [PERIOD_WIDTH-1:0] period_decrement,
  output swds_pkg::out_item_t     result
);
  import swds_pkg::*;

  localparam int SUB_W = PERIOD_WIDTH + 3;

  logic                    start_pending_r, start_pending_nxt;
  logic                    running_r, running_nxt;
  logic                    forward_r, forward_nxt;
  logic [1:0]              phase_index_r, phase_index_nxt;
  logic [PHASES_W-1:0]     phases_left_r, phases_left_nxt;
  logic [PERIOD_WIDTH-1:0] hold_count_r, hold_count_nxt;
  logic [PERIOD_WIDTH-1:0] phase_period_r, phase_period_nxt;
  logic [3:0]              coil_latch_r, coil_latch_nxt;

  logic [SUB_W-1:0]        sub;
  logic [SUB_W-1:0]        base_ext;
  logic [PERIOD_WIDTH-1:0] period_calc;
  logic [PHASES_W-1:0]     phases_dec;

  always_comb begin
    sub         = SUB_W'(item.speed_code) * SUB_W'(period_decrement);
    base_ext    = SUB_W'(base_period);
    period_calc = (base_ext > sub) ? PERIOD_WIDTH'(base_ext - sub) : '0;
    phases_dec  = phases_left_r - PHASES_W'(1);

    start_pending_nxt = start_pending_r;
    running_nxt       = running_r;
    forward_nxt       = forward_r;
    phase_index_nxt   = phase_index_r;
    phases_left_nxt   = phases_left_r;
    hold_count_nxt    = hold_count_r;
    phase_period_nxt  = phase_period_r;
    coil_latch_nxt    = coil_latch_r;

    if (running_r) begin
      if (hold_count_r != '0) begin
        hold_count_nxt = hold_count_r - PERIOD_WIDTH'(1);
      end else begin
        phases_left_nxt = phases_dec;
        if (phases_dec == '0) begin
          running_nxt       = 1'b0;
          start_pending_nxt = 1'b0;
        end else begin
          phase_index_nxt = phase_index_r + 2'd1;
          coil_latch_nxt  = pattern_at(forward_r, phase_index_r + 2'd1);
          hold_count_nxt  = phase_period_r;
        end
      end
    end else if (!item.enable_switch) begin
      start_pending_nxt = 1'b0;
    end else if (start_pending_r) begin
      start_pending_nxt = 1'b0;
      running_nxt       = 1'b1;
      forward_nxt       = item.direction;
      phases_left_nxt   = PHASES_W'(1) << item.step_code;
      phase_period_nxt  = period_calc;
      phase_index_nxt   = 2'd0;
      coil_latch_nxt    = pattern_at(item.direction, 2'd0);
      hold_count_nxt    = period_calc;
    end else if (item.start_press) begin
      start_pending_nxt = 1'b1;
    end

    result.coil_pattern = coil_latch_nxt;
    result.ready_led    = item.enable_switch & ~running_nxt;
    result.busy_res     = running_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pending_r <= 1'b0;
      running_r       <= 1'b0;
      forward_r       <= 1'b0;
      phase_index_r   <= '0;
      phases_left_r   <= '0;
      hold_count_r    <= '0;
      phase_period_r  <= '0;
      coil_latch_r    <= '0;
    end else if (step_en) begin
      start_pending_r <= start_pending_nxt;
      running_r       <= running_nxt;
      forward_r       <= forward_nxt;
      phase_index_r   <= phase_index_nxt;
      phases_left_r   <= phases_left_nxt;
      hold_count_r    <= hold_count_nxt;
      phase_period_r  <= phase_period_nxt;
      coil_latch_r    <= coil_latch_nxt;
    end
  end

endmodule

// ----- rtl/core/stepper_wave_drive_sequencer.sv -----
// top level of the stepper wave drive sequencer: input and result registers
// depends on swds_pkg, swds_cfg, swds_core and assert_macros.svh
//
//   channel  | ports                               | beat carries
//   ---------+-------------------------------------+-------------------------
//   in       | in_valid, in_stall, in_data         | one timer tick of inputs
//   out      | out_valid, out_stall, out_data      | coil drive and leds
//   cfg      | cfg_we, cfg_index, cfg_wdata        | one register write
//
// one beat per cycle sustained while out_stall is low; each beat is held in the input
// register and leaves through the result register when the result register advances
// the run state updates once per beat, so the loop through swds_core
// (one 3 x PERIOD_WIDTH product, a compare and a subtract) sets the clock
// a stalled result holds the input register; a second stalled beat waits
// at the port with in_stall high
// synchronous active-low reset clears the run state, both valids and the
// configuration registers to their defaults
`include "assert_macros.svh"

module stepper_wave_drive_sequencer #(
  parameter int PERIOD_WIDTH = 20
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_stall,
  input  swds_pkg::in_item_t      in_data,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output swds_pkg::out_item_t     out_data,
  // configuration port
  input  logic                    cfg_we,
  input  swds_pkg::cfg_idx_t      cfg_index,
  input  logic [PERIOD_WIDTH-1:0] cfg_wdata
);
  import swds_pkg::*;

  // input register
  logic      in_valid_r;
  in_item_t  in_data_r;
  // result register
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      advance;   // result register free or being drained
  logic      fire;      // beat in the input register is processed
  out_item_t result;

  logic [PERIOD_WIDTH-1:0] base_period;
  logic [PERIOD_WIDTH-1:0] period_decrement;

  assign advance  = ~out_valid_r | ~out_stall;
  assign fire     = in_valid_r & advance;
  assign in_stall = in_valid_r & ~advance;

  swds_cfg #(
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .base_period      (base_period),
    .period_decrement (period_decrement)
  );

  // run state advances once per processed beat
  swds_core #(
    .PERIOD_WIDTH(PERIOD_WIDTH)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step_en          (fire),
    .item             (in_data_r),
    .base_period      (base_period),
    .period_decrement (period_decrement),
    .result           (result)
  );

  // input register, payload has no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // at most one coil is driven
  `ASSERT_IMPL(a_coil_onehot, clk, rst_n, out_valid_r, $onehot0(out_data_r.coil_pattern),
               "more than one coil driven")
  // ready and busy exclude each other
  `ASSERT_IMPL(a_ready_busy, clk, rst_n, out_valid_r,
               !(out_data_r.ready_led && out_data_r.busy_res), "ready and busy both high")
  // input side only stalls behind a held result
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid_r && out_stall,
               "input stalled without a held result")

endmodule
